>>> design/pfa_pkg.sv
// ----------------------------------------------------------------------------
// Page frame allocator package
// Field widths, limits and operation codes shared by the allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package pfa_pkg;

  localparam int unsigned PAGE_SIZE_W = 16;
  localparam int unsigned OWNER_W     = 8;
  localparam int unsigned REQ_W       = 16;
  localparam int unsigned PIDX_W      = 4;
  localparam int unsigned FREED_W     = 5;

  // most pages one allocate word may be granted
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned NEED_W      = $clog2(MAX_RESULTS + 1);

  // quotient plus round-up carry
  localparam int unsigned QUOT_W      = REQ_W + 1;
  localparam int unsigned DIV_CNT_W   = $clog2(REQ_W);

  localparam logic [PAGE_SIZE_W-1:0] PAGE_SIZE_RST = 16'd20;

  localparam int unsigned IN_DATA_W   = 24;
  localparam int unsigned OUT_DATA_W  = 16;
  localparam int unsigned OUT_USER_W  = 2;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_e;

  typedef enum logic {
    ST_OK   = 1'b0,
    ST_FAIL = 1'b1
  } status_e;

endpackage

`default_nettype wire

>>> design/page_frame_allocator.sv
// ----------------------------------------------------------------------------
// Page frame allocator
// First-fit allocator over a table of page frames, each free or owned by an
// 8-bit owner; allocate and free-by-owner commands, one result word per grant.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: one command word. tuser = opcode (0 allocate, 1 free by owner),
//   tdata = owner_id, request_size. m_axis: result words, tlast on the final
//   one of each command. cfg_we_i/cfg_wdata_i write page_size (0 acts as 1).
//   Allocate: a 16-step restoring divider works out ceil(size/page_size),
//   then a scan over the frames grants the lowest free ones, one word per
//   page; the scan runs longest when the free frames sit high in the table.
//   A failed request gives one word with status 1 and changes nothing.
//   Free: the owner table is read one frame a cycle through a registered
//   read port, then one word with the freed count is sent.
//   One command at a time: s_axis_tready is high only between commands.
//   A stalled m_axis holds the result register; the grant scan waits on it.
//   Reset marks every frame free and sets page_size to 20; the owner table
//   needs no clearing since it is read only for frames marked used.
// ----------------------------------------------------------------------------
`default_nettype none

module page_frame_allocator #(
  parameter int unsigned NUM_PAGES = 16
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // configuration: page_size
  input  wire logic                                 cfg_we_i,
  input  wire logic [pfa_pkg::PAGE_SIZE_W-1:0]      cfg_wdata_i,
  // command stream
  input  wire logic                                 s_axis_tvalid,
  output      logic                                 s_axis_tready,
  // [7:0] owner_id, [23:8] request_size
  input  wire logic [pfa_pkg::IN_DATA_W-1:0]        s_axis_tdata,
  // [0] opcode
  input  wire logic                                 s_axis_tuser,
  // result stream
  output      logic                                 m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  // [3:0] page_index, [8:4] freed_count, [15:9] zero
  output      logic [pfa_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
  // [0] status, [1] page_valid
  output      logic [pfa_pkg::OUT_USER_W-1:0]       m_axis_tuser,
  output      logic                                 m_axis_tlast
);

  localparam int unsigned IW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int unsigned CW = $clog2(NUM_PAGES + 1);
  localparam int unsigned PW = (IW > pfa_pkg::PIDX_W) ? IW : pfa_pkg::PIDX_W;
  localparam int unsigned FW = (CW > pfa_pkg::FREED_W) ? CW : pfa_pkg::FREED_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_CHECK,
    S_GRANT,
    S_FAIL,
    S_FREE_SCAN,
    S_FREE_OUT
  } state_e;

  state_e                               state_q;
  logic [pfa_pkg::PAGE_SIZE_W-1:0]      page_size_q;
  logic [pfa_pkg::PAGE_SIZE_W-1:0]      divisor_q;
  logic [pfa_pkg::REQ_W-1:0]            dvd_q;     // dividend, becomes quotient
  logic [pfa_pkg::PAGE_SIZE_W-1:0]      rem_q;
  logic [pfa_pkg::DIV_CNT_W-1:0]        div_cnt_q;
  logic [pfa_pkg::OWNER_W-1:0]          owner_q;
  logic [pfa_pkg::NEED_W-1:0]           need_q;
  logic [pfa_pkg::NEED_W-1:0]           grant_cnt_q;
  logic [CW-1:0]                        idx_q;
  logic [CW-1:0]                        free_cnt_q;
  logic [CW-1:0]                        freed_q;
  logic [NUM_PAGES-1:0]                 frame_used_q;

  // owner table and its registered read port
  logic [pfa_pkg::OWNER_W-1:0]          owner_mem [NUM_PAGES];
  logic [pfa_pkg::OWNER_W-1:0]          owner_rd_q;
  logic [IW-1:0]                        chk_idx_q;
  logic                                 chk_vld_q;

  // result register
  logic                                 out_valid_q;
  logic                                 out_status_q;
  logic [pfa_pkg::PIDX_W-1:0]           out_pidx_q;
  logic                                 out_pval_q;
  logic [pfa_pkg::FREED_W-1:0]          out_freed_q;
  logic                                 out_last_q;

  logic                                 in_fire;
  logic                                 out_free;
  logic [IW-1:0]                        idx;
  logic                                 idx_used;
  logic                                 grant_fire;
  logic                                 idx_in_range;
  logic [pfa_pkg::PAGE_SIZE_W+1:0]      trial;
  logic [pfa_pkg::QUOT_W-1:0]           need_raw;
  logic [pfa_pkg::QUOT_W-1:0]           need;
  logic                                 alloc_fail;
  logic [PW-1:0]                        idx_ext;
  logic [FW-1:0]                        freed_ext;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  assign idx          = idx_q[IW-1:0];
  assign idx_in_range = (idx_q < CW'(NUM_PAGES));
  assign idx_used     = frame_used_q[idx];
  assign grant_fire   = (state_q == S_GRANT) && !idx_used && out_free;

  // single subtractor: one restoring-division step per cycle
  assign trial = {1'b0, rem_q, dvd_q[pfa_pkg::REQ_W-1]} - {2'b00, divisor_q};

  // round up, and never fewer than one page
  assign need_raw   = {1'b0, dvd_q} + pfa_pkg::QUOT_W'(rem_q != '0);
  assign need       = (need_raw == '0) ? pfa_pkg::QUOT_W'(1) : need_raw;
  assign alloc_fail = (need > pfa_pkg::QUOT_W'(pfa_pkg::MAX_RESULTS)) ||
                      (need > pfa_pkg::QUOT_W'(free_cnt_q));

  assign idx_ext   = PW'(idx);
  assign freed_ext = FW'(freed_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      page_size_q  <= pfa_pkg::PAGE_SIZE_RST;
      frame_used_q <= '0;
      free_cnt_q   <= CW'(NUM_PAGES);
      out_valid_q  <= 1'b0;
      chk_vld_q    <= 1'b0;
      idx_q        <= '0;
      grant_cnt_q  <= '0;
      freed_q      <= '0;
      div_cnt_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        page_size_q <= cfg_wdata_i;
      end
      if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      chk_vld_q <= 1'b0;

      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            owner_q     <= s_axis_tdata[pfa_pkg::OWNER_W-1:0];
            idx_q       <= '0;
            freed_q     <= '0;
            grant_cnt_q <= '0;
            if (pfa_pkg::opcode_e'(s_axis_tuser) == pfa_pkg::OP_FREE) begin
              state_q <= S_FREE_SCAN;
            end else begin
              dvd_q     <= s_axis_tdata[pfa_pkg::OWNER_W +: pfa_pkg::REQ_W];
              rem_q     <= '0;
              divisor_q <= (page_size_q == '0) ? pfa_pkg::PAGE_SIZE_W'(1)
                                               : page_size_q;
              div_cnt_q <= '1;
              state_q   <= S_DIV;
            end
          end
        end

        S_DIV: begin
          if (trial[pfa_pkg::PAGE_SIZE_W+1]) begin
            rem_q <= {rem_q[pfa_pkg::PAGE_SIZE_W-2:0], dvd_q[pfa_pkg::REQ_W-1]};
            dvd_q <= {dvd_q[pfa_pkg::REQ_W-2:0], 1'b0};
          end else begin
            rem_q <= trial[pfa_pkg::PAGE_SIZE_W-1:0];
            dvd_q <= {dvd_q[pfa_pkg::REQ_W-2:0], 1'b1};
          end
          div_cnt_q <= div_cnt_q - 1'b1;
          if (div_cnt_q == '0) begin
            state_q <= S_CHECK;
          end
        end

        S_CHECK: begin
          need_q <= need[pfa_pkg::NEED_W-1:0];
          if (alloc_fail) begin
            state_q <= S_FAIL;
          end else begin
            state_q <= S_GRANT;
          end
        end

        S_GRANT: begin
          // a grant is only issued once the result register can take it
          if (idx_used) begin
            idx_q <= idx_q + 1'b1;
          end else if (out_free) begin
            frame_used_q[idx] <= 1'b1;
            free_cnt_q        <= free_cnt_q - 1'b1;
            idx_q             <= idx_q + 1'b1;
            grant_cnt_q       <= grant_cnt_q + 1'b1;
            out_valid_q       <= 1'b1;
            out_status_q      <= pfa_pkg::ST_OK;
            out_pidx_q        <= idx_ext[pfa_pkg::PIDX_W-1:0];
            out_pval_q        <= 1'b1;
            out_freed_q       <= '0;
            out_last_q        <= (grant_cnt_q + 1'b1 == need_q);
            if (grant_cnt_q + 1'b1 == need_q) begin
              state_q <= S_IDLE;
            end
          end
        end

        S_FAIL: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_status_q <= pfa_pkg::ST_FAIL;
            out_pidx_q   <= '0;
            out_pval_q   <= 1'b0;
            out_freed_q  <= '0;
            out_last_q   <= 1'b1;
            state_q      <= S_IDLE;
          end
        end

        S_FREE_SCAN: begin
          // read issued at idx_q, compared in the following cycle at chk_idx_q
          if (idx_in_range) begin
            chk_idx_q <= idx;
            chk_vld_q <= 1'b1;
            idx_q     <= idx_q + 1'b1;
          end
          if (chk_vld_q && frame_used_q[chk_idx_q] && (owner_rd_q == owner_q)) begin
            frame_used_q[chk_idx_q] <= 1'b0;
            free_cnt_q              <= free_cnt_q + 1'b1;
            freed_q                 <= freed_q + 1'b1;
          end
          if (!idx_in_range && !chk_vld_q) begin
            state_q <= S_FREE_OUT;
          end
        end

        S_FREE_OUT: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_status_q <= pfa_pkg::ST_OK;
            out_pidx_q   <= '0;
            out_pval_q   <= 1'b0;
            out_freed_q  <= freed_ext[pfa_pkg::FREED_W-1:0];
            out_last_q   <= 1'b1;
            state_q      <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // owner table: written on a grant, read once a cycle during a free scan
  always_ff @(posedge clk_i) begin
    if (grant_fire) begin
      owner_mem[idx] <= owner_q;
    end
    if (idx_in_range) begin
      owner_rd_q <= owner_mem[idx];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = {out_pval_q, out_status_q};
  assign m_axis_tdata  = {{(pfa_pkg::OUT_DATA_W - pfa_pkg::PIDX_W - pfa_pkg::FREED_W){1'b0}},
                          out_freed_q, out_pidx_q};

  // free count tracks the used bits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_cnt_q == CW'(NUM_PAGES) - CW'($countones(frame_used_q)))
    else $error("free count out of step with used bits");

  // grant scan never overruns the page count it checked for
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_GRANT) |-> (grant_cnt_q < need_q) && idx_in_range)
    else $error("grant scan overran");

  // a failure word carries no page and closes the command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q == pfa_pkg::ST_FAIL) |-> (!out_pval_q && out_last_q))
    else $error("bad failure word");

  // one command at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !s_axis_tready)
    else $error("command taken while busy");

endmodule

`default_nettype wire

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Page frame allocator testbench
// Sends allocate and free-by-owner commands under several page sizes. A
// shadow frame table predicts the result words, and each one is checked as
// it leaves. Both streams idle and stall at random.
// ----------------------------------------------------------------------------

module tb_top;

  localparam int unsigned FRAMES      = 16;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned PHASE_WORDS = 42;

  typedef struct packed {
    pfa_pkg::status_e                 status;
    logic [pfa_pkg::PIDX_W-1:0]       page_index;
    logic                             page_valid;
    logic [pfa_pkg::FREED_W-1:0]      freed_count;
    logic                             last;
  } result_word_t;

  // shadow frame table and the result words it predicts
  class page_grant_board;
    logic [pfa_pkg::OWNER_W-1:0]     frame_owner [FRAMES];
    bit                              frame_used  [FRAMES];
    logic [pfa_pkg::PAGE_SIZE_W-1:0] page_size;
    result_word_t                    pending_words[$];
    int unsigned                     mismatches, words_seen, grants, refusals, frees;

    function new();
      foreach (frame_used[i]) begin
        frame_used[i]  = 1'b0;
        frame_owner[i] = '0;
      end
      page_size = pfa_pkg::PAGE_SIZE_RST;
    endfunction

    function void set_page_size(logic [pfa_pkg::PAGE_SIZE_W-1:0] value);
      page_size = value;
    endfunction

    function int unsigned outstanding();
      return pending_words.size();
    endfunction

    function void add_word(result_word_t w);
      pending_words.insert(pending_words.size(), w);
    endfunction

    function void note_command(pfa_pkg::opcode_e op, logic [pfa_pkg::OWNER_W-1:0] owner,
                               logic [pfa_pkg::REQ_W-1:0] size);
      int unsigned  unit, need, free_frames, k;
      result_word_t w;
      if (op == pfa_pkg::OP_FREE) begin
        k = 0;
        for (int i = 0; i < FRAMES; i++) begin
          if (frame_used[i] && frame_owner[i] == owner) begin
            frame_used[i] = 1'b0;
            k++;
          end
        end
        w = '{pfa_pkg::ST_OK, '0, 1'b0, pfa_pkg::FREED_W'(k), 1'b1};
        add_word(w);
        frees++;
        return;
      end
      unit = (page_size == 0) ? 1 : page_size;
      need = (int'(size) + unit - 1) / unit;
      if (need == 0) need = 1;
      free_frames = 0;
      foreach (frame_used[i]) if (!frame_used[i]) free_frames++;
      if (need > free_frames || need > pfa_pkg::MAX_RESULTS) begin
        w = '{pfa_pkg::ST_FAIL, '0, 1'b0, '0, 1'b1};
        add_word(w);
        refusals++;
        return;
      end
      k = 0;
      for (int i = 0; i < FRAMES && k < need; i++) begin
        if (!frame_used[i]) begin
          frame_used[i]  = 1'b1;
          frame_owner[i] = owner;
          k++;
          w = '{pfa_pkg::ST_OK, pfa_pkg::PIDX_W'(i), 1'b1, '0, (k == need)};
          add_word(w);
        end
      end
      grants++;
    endfunction

    task report(string msg);
      mismatches++;
      $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    task check_word(logic [pfa_pkg::OUT_DATA_W-1:0] data,
                    logic [pfa_pkg::OUT_USER_W-1:0] user, logic tlast);
      result_word_t want;
      words_seen++;
      if (pending_words.size() == 0) begin
        report($sformatf("unexpected result word data=%h user=%b last=%b",
                         data, user, tlast));
        return;
      end
      want = pending_words.pop_front();
      if (user[0] !== logic'(want.status))
        report($sformatf("status %b, want %b", user[0], want.status));
      if (data[3:0] !== want.page_index)
        report($sformatf("page_index %0d, want %0d", data[3:0], want.page_index));
      if (user[1] !== want.page_valid)
        report($sformatf("page_valid %b, want %b", user[1], want.page_valid));
      if (data[8:4] !== want.freed_count)
        report($sformatf("freed_count %0d, want %0d", data[8:4], want.freed_count));
      if (tlast !== want.last)
        report($sformatf("tlast %b, want %b", tlast, want.last));
    endtask
  endclass

  logic                              clk_i;
  logic                              rst_ni        = 1'b0;
  logic                              cfg_we_i      = 1'b0;
  logic [pfa_pkg::PAGE_SIZE_W-1:0]   cfg_wdata_i   = '0;
  logic                              s_axis_tvalid = 1'b0;
  logic                              s_axis_tready;
  logic [pfa_pkg::IN_DATA_W-1:0]     s_axis_tdata  = '0;
  logic                              s_axis_tuser  = 1'b0;
  logic                              m_axis_tvalid;
  logic                              m_axis_tready = 1'b0;
  logic [pfa_pkg::OUT_DATA_W-1:0]    m_axis_tdata;
  logic [pfa_pkg::OUT_USER_W-1:0]    m_axis_tuser;
  logic                              m_axis_tlast;

  page_grant_board board = new();
  int unsigned     cycles = 0;
  int unsigned     stall_left = 0;
  bit              sink_calm = 1'b0;
  bit              source_calm = 1'b0;

  page_frame_allocator #(.NUM_PAGES(FRAMES)) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles", cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result side: check accepted words, then pick next cycle's tready
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready)
        board.check_word(m_axis_tdata, m_axis_tuser, m_axis_tlast);
      if ($urandom_range(0, 63) == 0) sink_calm = ~sink_calm;
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (sink_calm || $urandom_range(0, 99) < 70) begin
        m_axis_tready <= 1'b1;
      end else begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(0, 2);
        m_axis_tready <= 1'b0;
      end
    end
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (source_calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // a word left valid after a handshake carries straight on into the next one
  task automatic send_command(pfa_pkg::opcode_e op, logic [pfa_pkg::OWNER_W-1:0] owner,
                              logic [pfa_pkg::REQ_W-1:0] size);
    int unsigned gap;
    gap = gap_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {size, owner};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_command(op, owner, size);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_page_size(logic [pfa_pkg::PAGE_SIZE_W-1:0] value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    board.set_page_size(value);
  endtask

  // mostly requests of a few pages at the current page size
  function automatic logic [pfa_pkg::REQ_W-1:0] pick_size(
      logic [pfa_pkg::PAGE_SIZE_W-1:0] ps);
    int unsigned unit, n, v, r;
    unit = (ps == 0) ? 1 : ps;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 15) return pfa_pkg::REQ_W'($urandom_range(0, 65535));
    n = (r < 20) ? $urandom_range(7, 17) : $urandom_range(1, 6);
    v = (n - 1) * unit + $urandom_range(1, unit);
    return (v > 65535) ? 16'hFFFF : pfa_pkg::REQ_W'(v);
  endfunction

  initial begin
    logic [pfa_pkg::PAGE_SIZE_W-1:0] ps;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // page size 20 from reset: fill the table, refuse, release
    send_command(pfa_pkg::OP_FREE,  8'd0,   16'd0);
    send_command(pfa_pkg::OP_ALLOC, 8'd0,   16'd0);
    send_command(pfa_pkg::OP_ALLOC, 8'd255, 16'd21);
    send_command(pfa_pkg::OP_ALLOC, 8'd255, 16'hFFFF);
    send_command(pfa_pkg::OP_FREE,  8'd255, 16'hFFFF);
    send_command(pfa_pkg::OP_ALLOC, 8'd3,   16'd300);
    send_command(pfa_pkg::OP_ALLOC, 8'd9,   16'd1);
    send_command(pfa_pkg::OP_FREE,  8'd0,   16'd0);
    send_command(pfa_pkg::OP_FREE,  8'd3,   16'd0);
    send_command(pfa_pkg::OP_ALLOC, 8'd1,   16'd320);
    send_command(pfa_pkg::OP_FREE,  8'd1,   16'd0);

    // unit pages: whole table, one over the limit, empty request
    write_page_size(16'd1);
    send_command(pfa_pkg::OP_ALLOC, 8'hAA,  16'd16);
    send_command(pfa_pkg::OP_FREE,  8'hAA,  16'd0);
    send_command(pfa_pkg::OP_ALLOC, 8'h55,  16'd17);
    send_command(pfa_pkg::OP_ALLOC, 8'h55,  16'd0);
    send_command(pfa_pkg::OP_FREE,  8'h55,  16'd0);

    write_page_size(16'hFFFF);
    send_command(pfa_pkg::OP_ALLOC, 8'd7,   16'hFFFF);
    send_command(pfa_pkg::OP_ALLOC, 8'd7,   16'd1);
    send_command(pfa_pkg::OP_FREE,  8'd7,   16'd0);

    // zero page size acts as one
    write_page_size(16'd0);
    send_command(pfa_pkg::OP_ALLOC, 8'd4,   16'd3);
    send_command(pfa_pkg::OP_FREE,  8'd4,   16'd0);

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: ps = 16'd1;
        1: ps = 16'hFFFF;
        2: ps = 16'd20;
        3: ps = pfa_pkg::PAGE_SIZE_W'($urandom_range(2, 100));
        4: ps = 16'd0;
        default: ps = pfa_pkg::PAGE_SIZE_W'($urandom_range(1, 65535));
      endcase
      write_page_size(ps);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if ($urandom_range(0, 19) == 0) source_calm = ~source_calm;
        send_command(pfa_pkg::opcode_e'(($urandom_range(0, 99) < 30) ? pfa_pkg::OP_FREE
                                                                      : pfa_pkg::OP_ALLOC),
                     ($urandom_range(0, 99) < 80)
                       ? pfa_pkg::OWNER_W'($urandom_range(0, 5))
                       : pfa_pkg::OWNER_W'($urandom_range(0, 255)),
                     pick_size(ps));
      end
    end

    drain();
    $display("Covered %0d granted, %0d refused and %0d free commands over ten page sizes,",
             board.grants, board.refusals, board.frees);
    $display("%0d result words checked, %0d mismatches", board.words_seen,
             board.mismatches);
    if (board.mismatches == 0 && board.outstanding() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/pfa_pkg.sv
design/page_frame_allocator.sv
verif/tb_top.sv
